>>> sv/ard_pkg.sv
// Shared types and constants for the address range decoder.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package ard_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAN  = 2'd3
  } action_e;

  // removed_count is a fixed 4-bit field that saturates
  localparam int unsigned COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Flags that ride along the cell chain during a scan
  typedef struct packed {
    logic hit;
    logic overlap;
    logic free_found;
    logic best_found;
  } scan_flags_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic do_clean;
    logic rank_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/ard_cell.sv
// One region slot of the address map plus its stage of the scan chain.
// Depends on ard_pkg.
`default_nettype none

module ard_cell import ard_pkg::*; #(
  parameter int unsigned NUM_REGIONS = 8,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned TARGET_BITS = 4,
  parameter int unsigned CELL_IDX    = 0,
  localparam int unsigned IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // command, held stable for the whole item
  input  wire logic [ADDR_BITS-1:0]   addr_first_i,
  input  wire logic [ADDR_BITS-1:0]   addr_last_i,
  input  wire logic [TARGET_BITS-1:0] target_i,
  // broadcast update controls
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [IDX_W-1:0]       sel_idx_i,
  input  wire logic [IDX_W-1:0]       rank_t_i,
  input  wire logic [IDX_W-1:0]       rank_sub_i,
  // scan chain, from the left neighbor
  input  wire scan_flags_t            flags_i,
  input  wire logic [TARGET_BITS-1:0] hit_target_i,
  input  wire logic [ADDR_BITS-1:0]   offset_i,
  input  wire logic [IDX_W-1:0]       free_idx_i,
  input  wire logic [IDX_W-1:0]       best_idx_i,
  input  wire logic [IDX_W-1:0]       best_age_i,
  input  wire logic [COUNT_W-1:0]     count_i,
  input  wire logic [NUM_REGIONS-1:0] mask_i,
  // scan chain, registered toward the right neighbor
  output scan_flags_t                 flags_o,
  output logic [TARGET_BITS-1:0]      hit_target_o,
  output logic [ADDR_BITS-1:0]        offset_o,
  output logic [IDX_W-1:0]            free_idx_o,
  output logic [IDX_W-1:0]            best_idx_o,
  output logic [IDX_W-1:0]            best_age_o,
  output logic [COUNT_W-1:0]          count_o,
  output logic [NUM_REGIONS-1:0]      mask_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                   valid_q, valid_d;
  logic [ADDR_BITS-1:0]   first_q, last_q;
  logic [TARGET_BITS-1:0] tgt_q;
  logic [IDX_W-1:0]       age_q, age_d;
  logic                   write_en;

  logic in_range, overlap, take_best;

  scan_flags_t            flags_d, flags_q;
  logic [TARGET_BITS-1:0] hit_target_d, hit_target_q;
  logic [ADDR_BITS-1:0]   offset_d, offset_q;
  logic [IDX_W-1:0]       free_idx_d, free_idx_q;
  logic [IDX_W-1:0]       best_idx_d, best_idx_q;
  logic [IDX_W-1:0]       best_age_d, best_age_q;
  logic [COUNT_W-1:0]     count_d, count_q;
  logic [NUM_REGIONS-1:0] mask_d, mask_q;

  assign in_range  = valid_q && (addr_first_i >= first_q) && (addr_first_i <= last_q);
  assign overlap   = valid_q && (first_q <= addr_last_i) && (last_q >= addr_first_i);
  assign take_best = valid_q && (tgt_q == target_i) &&
                     (!flags_i.best_found || (age_q < best_age_i));

  // scan stage: first hit and first free slot win, youngest target match wins
  always_comb begin
    flags_d      = flags_i;
    hit_target_d = hit_target_i;
    offset_d     = offset_i;
    free_idx_d   = free_idx_i;
    best_idx_d   = best_idx_i;
    best_age_d   = best_age_i;
    count_d      = count_i;
    mask_d       = mask_i;
    if (in_range && !flags_i.hit) begin
      flags_d.hit  = 1'b1;
      hit_target_d = tgt_q;
      offset_d     = addr_first_i - first_q;
    end
    if (overlap) begin
      flags_d.overlap = 1'b1;
      mask_d[age_q]   = 1'b1;
      if (count_i != COUNT_MAX) begin
        count_d = count_i + 1'b1;
      end
    end
    if (!valid_q && !flags_i.free_found) begin
      flags_d.free_found = 1'b1;
      free_idx_d         = MY_IDX;
    end
    if (take_best) begin
      flags_d.best_found = 1'b1;
      best_idx_d         = MY_IDX;
      best_age_d         = age_q;
    end
  end

  // slot update
  always_comb begin
    valid_d  = valid_q;
    age_d    = age_q;
    write_en = 1'b0;
    if (ctrl_i.do_insert) begin
      if (sel_idx_i == MY_IDX) begin
        valid_d  = 1'b1;
        age_d    = '0;
        write_en = 1'b1;
      end else if (valid_q) begin
        age_d = age_q + 1'b1;
      end
    end
    if (ctrl_i.do_remove && (sel_idx_i == MY_IDX)) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.do_clean && overlap) begin
      valid_d = 1'b0;
    end
    // rank compaction: survivor of age t drops by the number of removed younger ages
    if (ctrl_i.rank_en && valid_q && (age_q == rank_t_i)) begin
      age_d = rank_t_i - rank_sub_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q        <= age_d;
    hit_target_q <= hit_target_d;
    offset_q     <= offset_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    count_q      <= count_d;
    mask_q       <= mask_d;
    if (write_en) begin
      first_q <= addr_first_i;
      last_q  <= addr_last_i;
      tgt_q   <= target_i;
    end
  end

  assign flags_o      = flags_q;
  assign hit_target_o = hit_target_q;
  assign offset_o     = offset_q;
  assign free_idx_o   = free_idx_q;
  assign best_idx_o   = best_idx_q;
  assign best_age_o   = best_age_q;
  assign count_o      = count_q;
  assign mask_o       = mask_q;

endmodule

`default_nettype wire

>>> sv/address_range_decoder_unit.sv
// Address range decoder top level: command sequencer and the row of region cells.
// Depends on ard_pkg and ard_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command beat: action,
//   first and last address and target id. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result beat per command.
//   A beat moves on a rising edge with valid high and stall low.
//   Each command scans the cell chain one cell per cycle and then applies its
//   decision; a remove or a clean that takes out a region adds a pass of age
//   compaction, one age rank per cycle. The next command is accepted the
//   cycle after the result is loaded into the output register, so a new
//   command is taken only once the unit is through with the last one.
//   A result that waits on out_stall_i holds in the output register while the
//   following command is taken and scanned; only the final load waits for it.
//   Reset empties the table (all regions invalid) and drops any pending beat.
`default_nettype none

module address_range_decoder_unit import ard_pkg::*; #(
  parameter int unsigned NUM_REGIONS = 8,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned TARGET_BITS = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             action_i,
  input  wire logic [ADDR_BITS-1:0]   first_address_i,
  input  wire logic [ADDR_BITS-1:0]   last_address_i,
  input  wire logic [TARGET_BITS-1:0] target_id_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        ok_o,
  output logic [TARGET_BITS-1:0]      hit_target_o,
  output logic [ADDR_BITS-1:0]        offset_o,
  output logic                        table_full_o,
  output logic [COUNT_W-1:0]          removed_count_o
);

  localparam int unsigned IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGIONS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_RANK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] rsub_q, rsub_d;
  logic [NUM_REGIONS-1:0] rmask_q, rmask_d;

  // command register
  action_e                act_q;
  logic [ADDR_BITS-1:0]   first_q, last_q;
  logic [TARGET_BITS-1:0] tgt_q;
  logic                   span_ok_q;
  logic                   in_fire;

  // pending result and output register
  logic                   res_ok_q, res_ok_d;
  logic [TARGET_BITS-1:0] res_tgt_q, res_tgt_d;
  logic [ADDR_BITS-1:0]   res_off_q, res_off_d;
  logic                   res_full_q, res_full_d;
  logic [COUNT_W-1:0]     res_cnt_q, res_cnt_d;
  logic                   out_valid_q;
  logic                   out_load;
  logic                   out_ok_q, out_full_q;
  logic [TARGET_BITS-1:0] out_tgt_q;
  logic [ADDR_BITS-1:0]   out_off_q;
  logic [COUNT_W-1:0]     out_cnt_q;

  cell_ctrl_t       ctrl;
  logic [IDX_W-1:0] sel_idx;
  logic             rank_go;

  // scan chain taps; index 0 is the empty seed
  scan_flags_t            flags_c      [NUM_REGIONS+1];
  logic [TARGET_BITS-1:0] hit_target_c [NUM_REGIONS+1];
  logic [ADDR_BITS-1:0]   offset_c     [NUM_REGIONS+1];
  logic [IDX_W-1:0]       free_idx_c   [NUM_REGIONS+1];
  logic [IDX_W-1:0]       best_idx_c   [NUM_REGIONS+1];
  logic [IDX_W-1:0]       best_age_c   [NUM_REGIONS+1];
  logic [COUNT_W-1:0]     count_c      [NUM_REGIONS+1];
  logic [NUM_REGIONS-1:0] mask_c       [NUM_REGIONS+1];

  assign flags_c[0]      = '0;
  assign hit_target_c[0] = '0;
  assign offset_c[0]     = '0;
  assign free_idx_c[0]   = '0;
  assign best_idx_c[0]   = '0;
  assign best_age_c[0]   = '0;
  assign count_c[0]      = '0;
  assign mask_c[0]       = '0;

  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
    ard_cell #(
      .NUM_REGIONS (NUM_REGIONS),
      .ADDR_BITS   (ADDR_BITS),
      .TARGET_BITS (TARGET_BITS),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .addr_first_i (first_q),
      .addr_last_i  (last_q),
      .target_i     (tgt_q),
      .ctrl_i       (ctrl),
      .sel_idx_i    (sel_idx),
      .rank_t_i     (step_q),
      .rank_sub_i   (rsub_q),
      .flags_i      (flags_c[g]),
      .hit_target_i (hit_target_c[g]),
      .offset_i     (offset_c[g]),
      .free_idx_i   (free_idx_c[g]),
      .best_idx_i   (best_idx_c[g]),
      .best_age_i   (best_age_c[g]),
      .count_i      (count_c[g]),
      .mask_i       (mask_c[g]),
      .flags_o      (flags_c[g+1]),
      .hit_target_o (hit_target_c[g+1]),
      .offset_o     (offset_c[g+1]),
      .free_idx_o   (free_idx_c[g+1]),
      .best_idx_o   (best_idx_c[g+1]),
      .best_age_o   (best_age_c[g+1]),
      .count_o      (count_c[g+1]),
      .mask_o       (mask_c[g+1])
    );
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // decision from the tail of the chain, valid in S_APPLY
  always_comb begin
    res_ok_d   = 1'b0;
    res_tgt_d  = '0;
    res_off_d  = '0;
    res_full_d = 1'b0;
    res_cnt_d  = '0;
    sel_idx    = free_idx_c[NUM_REGIONS];
    rmask_d    = rmask_q;
    rank_go    = 1'b0;
    ctrl       = '0;
    case (act_q)
      ACT_LOOKUP: begin
        res_ok_d  = flags_c[NUM_REGIONS].hit;
        res_tgt_d = hit_target_c[NUM_REGIONS];
        res_off_d = offset_c[NUM_REGIONS];
      end
      ACT_INSERT: begin
        if (span_ok_q && !flags_c[NUM_REGIONS].overlap) begin
          if (flags_c[NUM_REGIONS].free_found) begin
            res_ok_d       = 1'b1;
            ctrl.do_insert = 1'b1;
          end else begin
            res_full_d = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        sel_idx = best_idx_c[NUM_REGIONS];
        if (flags_c[NUM_REGIONS].best_found) begin
          res_ok_d       = 1'b1;
          res_cnt_d      = COUNT_W'(1);
          ctrl.do_remove = 1'b1;
          rmask_d        = '0;
          rmask_d[best_age_c[NUM_REGIONS]] = 1'b1;
          rank_go        = 1'b1;
        end
      end
      ACT_CLEAN: begin
        if (span_ok_q && (count_c[NUM_REGIONS] != '0)) begin
          res_cnt_d     = count_c[NUM_REGIONS];
          ctrl.do_clean = 1'b1;
          rmask_d       = mask_c[NUM_REGIONS];
          rank_go       = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state_q != S_APPLY) begin
      ctrl.do_insert = 1'b0;
      ctrl.do_remove = 1'b0;
      ctrl.do_clean  = 1'b0;
    end
    ctrl.rank_en = (state_q == S_RANK);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rsub_d  = rsub_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_WALK;
          step_d  = '0;
        end
      end
      S_WALK: begin
        // tail cell holds the full scan once every stage has been clocked
        if (step_q == LAST_IDX) begin
          state_d = S_APPLY;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_APPLY: begin
        step_d = '0;
        rsub_d = '0;
        state_d = rank_go ? S_RANK : S_DONE;
      end
      S_RANK: begin
        rsub_d = rsub_q + IDX_W'(rmask_q[step_q]);
        if (step_q == LAST_IDX) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      rsub_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rsub_q  <= rsub_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q     <= action_e'(action_i);
      first_q   <= first_address_i;
      last_q    <= last_address_i;
      tgt_q     <= target_id_i;
      span_ok_q <= (first_address_i <= last_address_i);
    end
    if (state_q == S_APPLY) begin
      res_ok_q   <= res_ok_d;
      res_tgt_q  <= res_tgt_d;
      res_off_q  <= res_off_d;
      res_full_q <= res_full_d;
      res_cnt_q  <= res_cnt_d;
      rmask_q    <= rmask_d;
    end
    if (out_load) begin
      out_ok_q   <= res_ok_q;
      out_tgt_q  <= res_tgt_q;
      out_off_q  <= res_off_q;
      out_full_q <= res_full_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign hit_target_o    = out_tgt_q;
  assign offset_o        = out_off_q;
  assign table_full_o    = out_full_q;
  assign removed_count_o = out_cnt_q;

endmodule

`default_nettype wire

>>> sv/ard_checker.sv
// Port-level checks for the address range decoder, bound to the top level.
// Depends on ard_pkg and address_range_decoder_unit.
`default_nettype none

module ard_checker import ard_pkg::*; #(
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned TARGET_BITS = 4
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic                   ok_o,
  input wire logic [TARGET_BITS-1:0] hit_target_o,
  input wire logic [ADDR_BITS-1:0]   offset_o,
  input wire logic                   table_full_o,
  input wire logic [COUNT_W-1:0]     removed_count_o
);

  // one command in flight: a taken beat closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a command was in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(ok_o) &&
      $stable(offset_o) && $stable(removed_count_o)))
    else $error("stalled result beat changed");

  a_ok_vs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ok_o && table_full_o))
    else $error("ok and table_full both set");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> ((hit_target_o == '0) && (offset_o == '0)))
    else $error("target or offset nonzero without a hit");

  a_full_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (removed_count_o == '0))
    else $error("full insert reported removals");

endmodule

bind address_range_decoder_unit ard_checker #(
  .ADDR_BITS   (ADDR_BITS),
  .TARGET_BITS (TARGET_BITS)
) u_ard_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .ok_o            (ok_o),
  .hit_target_o    (hit_target_o),
  .offset_o        (offset_o),
  .table_full_o    (table_full_o),
  .removed_count_o (removed_count_o)
);

`default_nettype wire

>>> tb/addr_map_tb_pkg.sv
// Command/result types and the region table scoreboard for the address range decoder bench.
// Depends on ard_pkg for the action codes and the removed_count width.
package addr_map_tb_pkg;
  import ard_pkg::*;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TGT_W     = 4;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [TGT_W-1:0]  target;
  } map_cmd_t;

  typedef struct packed {
    logic               ok;
    logic [TGT_W-1:0]   hit_target;
    logic [ADDR_W-1:0]  offset;
    logic               table_full;
    logic [COUNT_W-1:0] removed_count;
  } map_result_t;

  class region_scoreboard;
    bit                used [NUM_SLOTS];
    logic [ADDR_W-1:0] lo   [NUM_SLOTS];
    logic [ADDR_W-1:0] hi   [NUM_SLOTS];
    logic [TGT_W-1:0]  tgt  [NUM_SLOTS];
    int unsigned       age  [NUM_SLOTS];
    map_result_t       expected_q [$];
    int unsigned       errors;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        lo[i]   = '0;
        hi[i]   = '0;
        tgt[i]  = '0;
        age[i]  = 0;
      end
      errors = 0;
    endfunction

    // Ages of live regions are packed back to 0..n-1, order kept.
    function void compact_ages();
      int unsigned fresh [NUM_SLOTS];
      foreach (fresh[i]) begin
        fresh[i] = 0;
        if (used[i]) begin
          foreach (used[j]) begin
            if (used[j] && age[j] < age[i]) fresh[i]++;
          end
        end
      end
      age = fresh;
    endfunction

    function map_result_t decode(map_cmd_t c);
      map_result_t r;
      int          best;
      int          slot;
      bit          overlap;
      r = '0;
      case (c.action)
        ACT_LOOKUP: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i] && c.first >= lo[i] && c.first <= hi[i]) begin
              r.ok         = 1'b1;
              r.hit_target = tgt[i];
              r.offset     = c.first - lo[i];
              break;
            end
          end
        end
        ACT_INSERT: begin
          if (c.first <= c.last) begin
            overlap = 1'b0;
            slot    = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (used[i]) begin
                if (lo[i] <= c.last && hi[i] >= c.first) overlap = 1'b1;
              end else if (slot < 0) begin
                slot = i;
              end
            end
            if (!overlap) begin
              if (slot < 0) begin
                r.table_full = 1'b1;
              end else begin
                foreach (used[i]) begin
                  if (used[i]) age[i]++;
                end
                used[slot] = 1'b1;
                lo[slot]   = c.first;
                hi[slot]   = c.last;
                tgt[slot]  = c.target;
                age[slot]  = 0;
                r.ok       = 1'b1;
              end
            end
          end
        end
        ACT_REMOVE: begin
          best = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i] && tgt[i] == c.target && (best < 0 || age[i] < age[best])) best = i;
          end
          if (best >= 0) begin
            used[best] = 1'b0;
            compact_ages();
            r.ok            = 1'b1;
            r.removed_count = COUNT_W'(1);
          end
        end
        default: begin
          // clean: any live region touching the span goes, whatever its target
          if (c.first <= c.last) begin
            foreach (used[i]) begin
              if (used[i] && lo[i] <= c.last && hi[i] >= c.first) begin
                used[i] = 1'b0;
                if (r.removed_count != COUNT_MAX) r.removed_count++;
              end
            end
            if (r.removed_count != 0) compact_ages();
          end
        end
      endcase
      return r;
    endfunction

    function void note_command(map_cmd_t c);
      expected_q.push_back(decode(c));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Some address inside a live region, so that lookups hit often; a random address when none is live.
    function logic [ADDR_W-1:0] addr_in_region();
      int live [$];
      int k;
      foreach (used[i]) begin
        if (used[i]) live.push_back(i);
      end
      if (live.size() == 0) return $urandom();
      k = live[$urandom_range(0, live.size() - 1)];
      return lo[k] + $urandom_range(0, hi[k] - lo[k]);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(map_result_t got);
      map_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing pending: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %b want %b", got.ok, want.ok));
      if (got.hit_target !== want.hit_target)
        report($sformatf("hit_target got %0h want %0h", got.hit_target, want.hit_target));
      if (got.offset !== want.offset)
        report($sformatf("offset got %h want %h", got.offset, want.offset));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full got %b want %b", got.table_full, want.table_full));
      if (got.removed_count !== want.removed_count)
        report($sformatf("removed_count got %0d want %0d",
                         got.removed_count, want.removed_count));
    endtask
  endclass

endpackage

>>> tb/tb.sv
// Top-level bench for address_range_decoder_unit: directed and random table commands.
// Depends on ard_pkg, addr_map_tb_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ard_pkg::*;
  import addr_map_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_SLOTS + 24;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [ADDR_W-1:0] first_address_i;
  logic [ADDR_W-1:0] last_address_i;
  logic [TGT_W-1:0]  target_id_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ok_o;
  logic [TGT_W-1:0]  hit_target_o;
  logic [ADDR_W-1:0] offset_o;
  logic              table_full_o;
  logic [COUNT_W-1:0] removed_count_o;

  region_scoreboard sb = new();
  bit               quiet = 1'b0;
  int unsigned      gapless_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      run_left = 0;
  int unsigned      cycles = 0;

  address_range_decoder_unit #(
    .NUM_REGIONS(NUM_SLOTS),
    .ADDR_BITS  (ADDR_W),
    .TARGET_BITS(TGT_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .first_address_i(first_address_i),
    .last_address_i (last_address_i),
    .target_id_i    (target_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .hit_target_o   (hit_target_o),
    .offset_o       (offset_o),
    .table_full_o   (table_full_o),
    .removed_count_o(removed_count_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side stall: random stall bursts between stall-free stretches, no stall while quiet
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      run_left = $urandom_range(1, 60);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{ok: ok_o, hit_target: hit_target_o, offset: offset_o,
                        table_full: table_full_o, removed_count: removed_count_o});
    end
  end

  // Drives one command beat and returns at the edge that took it.
  task automatic send_command(action_e act, logic [ADDR_W-1:0] first,
                              logic [ADDR_W-1:0] last, logic [TGT_W-1:0] target);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    first_address_i <= first;
    last_address_i  <= last;
    target_id_i     <= target;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command('{action: act, first: first, last: last, target: target});
  endtask

  task automatic sender_gap();
    if (quiet) return;
    if (gapless_left > 0) begin
      gapless_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      gapless_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Mostly addresses on a coarse grid so regions collide; some full-range values.
  function automatic logic [ADDR_W-1:0] grid_addr();
    logic [3:0]  slot;
    logic [11:0] low;
    slot = 4'($urandom_range(0, 15));
    low  = 12'($urandom_range(0, 'hFFF));
    case ($urandom_range(0, 15))
      0:       return $urandom();
      1:       return '0;
      2:       return '1;
      default: return {slot, 16'h0000, low};
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] span_len(bit wide);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom();
      2:       return wide ? ADDR_W'($urandom_range(1, 3)) << 28 : $urandom_range(0, 'hFFF);
      default: return $urandom_range(0, 'h3FF);
    endcase
  endfunction

  task automatic random_command();
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] swap;
    logic [TGT_W-1:0]  target;
    int unsigned       pick;
    pick   = $urandom_range(0, 99);
    target = $urandom_range(0, 1) ? TGT_W'($urandom_range(0, 3))
                                  : TGT_W'($urandom_range(0, 15));
    first  = grid_addr();
    last   = first + span_len(pick >= 88);
    // a few deliberately inverted ranges
    if ($urandom_range(0, 19) == 0 && first != last) begin
      swap  = first;
      first = last;
      last  = swap;
    end
    if (pick < 45) begin
      if ($urandom_range(0, 2) != 0) first = sb.addr_in_region();
      send_command(ACT_LOOKUP, first, $urandom(), target);
    end else if (pick < 75) begin
      send_command(ACT_INSERT, first, last, target);
    end else if (pick < 88) begin
      send_command(ACT_REMOVE, $urandom(), $urandom(), target);
    end else begin
      send_command(ACT_CLEAN, first, last, target);
    end
  endtask

  task automatic directed_commands();
    send_command(ACT_LOOKUP, 32'h0000_0000, 32'h0, 4'd0);
    sender_gap();
    send_command(ACT_INSERT, 32'h0000_0000, 32'h0000_00FF, 4'd0);
    sender_gap();
    send_command(ACT_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd15);
    send_command(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
    send_command(ACT_LOOKUP, 32'h0000_0080, 32'h0, 4'd0);
    sender_gap();
    send_command(ACT_LOOKUP, 32'h0000_0100, 32'h0, 4'd0);
    // overlap with an existing region, then an inverted region
    send_command(ACT_INSERT, 32'h0000_0080, 32'h0000_0180, 4'd1);
    send_command(ACT_INSERT, 32'h0000_0300, 32'h0000_0200, 4'd1);
    // fill the table; target 3 appears more than once
    send_command(ACT_INSERT, 32'h0000_1000, 32'h0000_1FFF, 4'd3);
    send_command(ACT_INSERT, 32'h0000_2000, 32'h0000_2FFF, 4'd3);
    sender_gap();
    send_command(ACT_INSERT, 32'h0000_3000, 32'h0000_3FFF, 4'd5);
    send_command(ACT_INSERT, 32'h0000_4000, 32'h0000_4FFF, 4'd3);
    send_command(ACT_INSERT, 32'h0000_5000, 32'h0000_5FFF, 4'd7);
    send_command(ACT_INSERT, 32'h0000_6000, 32'h0000_6FFF, 4'd9);
    // full table, then overlap while full
    send_command(ACT_INSERT, 32'h0001_0000, 32'h0001_0FFF, 4'd2);
    send_command(ACT_INSERT, 32'h0000_0050, 32'h0000_0060, 4'd2);
    sender_gap();
    send_command(ACT_REMOVE, 32'h0, 32'h0, 4'd3);
    send_command(ACT_LOOKUP, 32'h0000_4000, 32'h0, 4'd0);
    send_command(ACT_REMOVE, 32'h0, 32'h0, 4'd4);
    send_command(ACT_CLEAN, 32'h0000_1800, 32'h0000_2800, 4'd0);
    send_command(ACT_CLEAN, 32'h0000_0200, 32'h0000_0100, 4'd0);
    sender_gap();
    send_command(ACT_INSERT, 32'h0000_4000, 32'h0000_4000, 4'd3);
    send_command(ACT_LOOKUP, 32'h0000_4000, 32'h0, 4'd0);
    send_command(ACT_CLEAN, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
    send_command(ACT_LOOKUP, 32'h0000_0080, 32'h0, 4'd0);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_LOOKUP;
    first_address_i <= '0;
    last_address_i  <= '0;
    target_id_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_commands();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      sender_gap();
      random_command();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
